@@ design/ymr_pkg.sv @@
// Package for the YMODEM packet receiver: word types, event and opcode codes,
// frame layout constants. No dependencies.
package ymr_pkg;

  localparam int unsigned CNT_W         = 11;
  localparam int unsigned SMALL_PAYLOAD = 128;
  localparam int unsigned LARGE_PAYLOAD = 1024;
  localparam int unsigned HDR_LEN       = 3;
  localparam int unsigned FRAME_EXTRA   = 5;

  localparam logic [7:0] CODE_SOH = 8'h01;
  localparam logic [7:0] CODE_STX = 8'h02;
  localparam logic [7:0] CODE_EOT = 8'h04;
  localparam logic [7:0] CODE_CAN = 8'h18;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } ymr_op_e;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_GOOD  = 3'd1,
    EV_ERROR = 3'd2,
    EV_EOT   = 3'd3,
    EV_CAN   = 3'd4
  } ymr_event_e;

  typedef struct packed {
    ymr_op_e     opcode;
    logic [7:0]  rx_byte;
    logic [9:0]  read_index;
  } ymr_in_t;

  typedef struct packed {
    ymr_event_e  event_res;
    logic [7:0]  block_number;
    logic [10:0] payload_size;
    logic [7:0]  read_data;
  } ymr_out_t;

  typedef struct packed {
    ymr_event_e  event_res;
    logic [7:0]  block_number;
    logic [10:0] payload_size;
  } ymr_res_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
    logic [7:0]       data;
  } ymr_wr_t;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] addr;
  } ymr_rd_t;

endpackage

@@ design/ymodem_packet_receiver.sv @@
// YMODEM packet receiver top level. A word's result is registered in the
// parser/buffer-read stage, then in the output register, which presents it.
// Throughput: one word per cycle while the output is not stalled, set by the
// single buffer port pair.
// Reset clears the parser state and the pipeline valids; the frame buffer is
// not cleared and holds stale bytes until overwritten.
// Depends on ymr_pkg, ymr_ctrl, ymr_store.
module ymodem_packet_receiver #(
  parameter int unsigned FRAME_DEPTH = 1029
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ymr_pkg::ymr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ymr_pkg::ymr_out_t out_data_o
);
  import ymr_pkg::*;

  logic       acc;
  logic       move;
  logic       s1_v_q;
  ymr_res_t   s1_res_q;
  logic       s1_rd_q;
  logic       out_v_q;
  ymr_out_t   out_q;
  ymr_res_t   res;
  ymr_wr_t    wr;
  ymr_rd_t    rd;
  logic [7:0] rdata;
  logic       rd_ok;

  assign move       = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || move;
  assign acc        = in_valid_i && in_ready_o;

  assign rd.addr = CNT_W'(HDR_LEN) + CNT_W'(in_data_i.read_index);
  assign rd_ok   = (32'(rd.addr) < FRAME_DEPTH);
  assign rd.en   = acc && (in_data_i.opcode == OP_READ) && rd_ok;

  ymr_ctrl #(.FRAME_DEPTH(FRAME_DEPTH)) u_ctrl (
    .clk_i,
    .rst_ni,
    .step_i   (acc && (in_data_i.opcode == OP_FEED)),
    .rx_byte_i(in_data_i.rx_byte),
    .res_o    (res),
    .wr_o     (wr)
  );

  ymr_store #(.DEPTH(FRAME_DEPTH)) u_store (
    .clk_i,
    .wr_i   (wr),
    .rd_i   (rd),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_q <= 1'b1;
      end else if (move) begin
        s1_v_q <= 1'b0;
      end
      if (move) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_res_q <= res;
      s1_rd_q  <= rd.en;
    end
    if (move) begin
      out_q.event_res    <= s1_res_q.event_res;
      out_q.block_number <= s1_res_q.block_number;
      out_q.payload_size <= s1_res_q.payload_size;
      out_q.read_data    <= s1_rd_q ? rdata : 8'h00;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

@@ design/ymr_store.sv @@
// Frame buffer: one write port, one read port with registered read data.
// Depends on ymr_pkg.
module ymr_store #(
  parameter int unsigned DEPTH = 1029
) (
  input  logic             clk_i,
  input  ymr_pkg::ymr_wr_t wr_i,
  input  ymr_pkg::ymr_rd_t rd_i,
  output logic [7:0]       rdata_o
);
  import ymr_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[AW-1:0]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ymr_ctrl.sv @@
// Frame parser: start detection, byte counting, header capture, CRC-16/XMODEM
// and the end-of-frame check. Drives the buffer write port. Depends on ymr_pkg.
module ymr_ctrl #(
  parameter int unsigned FRAME_DEPTH = 1029
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       rx_byte_i,
  output ymr_pkg::ymr_res_t res_o,
  output ymr_pkg::ymr_wr_t  wr_o
);
  import ymr_pkg::*;

  logic             coll_q, coll_d;
  logic             large_q, large_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       blk_q, blk_d;
  logic [7:0]       cpl_q, cpl_d;
  logic [7:0]       crc_hi_q, crc_hi_d;
  logic [CNT_W-1:0] size;
  logic [CNT_W-1:0] nxt;
  logic [7:0]       hdr_sum;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    end
    return c;
  endfunction

  always_comb begin
    coll_d   = coll_q;
    large_d  = large_q;
    cnt_d    = cnt_q;
    crc_d    = crc_q;
    blk_d    = blk_q;
    cpl_d    = cpl_q;
    crc_hi_d = crc_hi_q;
    res_o    = '{event_res: EV_NONE, block_number: 8'h00, payload_size: '0};
    wr_o     = '{en: 1'b0, addr: cnt_q, data: rx_byte_i};
    size     = large_q ? CNT_W'(LARGE_PAYLOAD) : CNT_W'(SMALL_PAYLOAD);
    nxt      = cnt_q + CNT_W'(1);
    hdr_sum  = blk_q + cpl_q;
    if (step_i) begin
      if (!coll_q) begin
        case (rx_byte_i)
          CODE_SOH, CODE_STX: begin
            wr_o.en   = 1'b1;
            wr_o.addr = '0;
            large_d   = (rx_byte_i == CODE_STX);
            cnt_d     = CNT_W'(1);
            crc_d     = 16'h0000;
            coll_d    = 1'b1;
          end
          CODE_EOT: res_o.event_res = EV_EOT;
          CODE_CAN: res_o.event_res = EV_CAN;
          default: ;
        endcase
      end else begin
        wr_o.en = (32'(cnt_q) < FRAME_DEPTH);
        if (cnt_q >= CNT_W'(HDR_LEN) && cnt_q < size + CNT_W'(HDR_LEN)) begin
          crc_d = crc_byte(crc_q, rx_byte_i);
        end
        if (cnt_q == CNT_W'(1)) begin
          blk_d = rx_byte_i;
        end
        if (cnt_q == CNT_W'(2)) begin
          cpl_d = rx_byte_i;
        end
        if (cnt_q == size + CNT_W'(HDR_LEN)) begin
          crc_hi_d = rx_byte_i;
        end
        cnt_d = nxt;
        if (nxt >= size + CNT_W'(FRAME_EXTRA)) begin
          if (hdr_sum == 8'hFF && {crc_hi_q, rx_byte_i} == crc_d) begin
            res_o.event_res    = EV_GOOD;
            res_o.block_number = blk_q;
            res_o.payload_size = size;
          end else begin
            res_o.event_res = EV_ERROR;
          end
          coll_d = 1'b0;
          cnt_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q  <= 1'b0;
      large_q <= 1'b0;
      cnt_q   <= '0;
      crc_q   <= 16'h0000;
    end else begin
      coll_q  <= coll_d;
      large_q <= large_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q    <= blk_d;
    cpl_q    <= cpl_d;
    crc_hi_q <= crc_hi_d;
  end

endmodule

@@ design/ymr_checker.sv @@
// Port-level checker for the YMODEM packet receiver, bound to the top level.
// Depends on ymr_pkg.
module ymr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ymr_pkg::ymr_out_t out_data_o
);
  import ymr_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_good_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res == EV_GOOD |->
      (out_data_o.payload_size == 11'd128 || out_data_o.payload_size == 11'd1024)
      && out_data_o.read_data == 8'h00)
    else $error("good packet with bad size or read data");

  a_no_info: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res != EV_GOOD |->
      out_data_o.block_number == 8'h00 && out_data_o.payload_size == 11'd0)
    else $error("block number or size on a non-packet word");

  a_read_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.read_data != 8'h00 |->
      out_data_o.event_res == EV_NONE)
    else $error("read data on an event word");

endmodule

bind ymodem_packet_receiver ymr_checker u_ymr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

@@ tb/tb.sv @@
// Self-checking testbench for ymodem_packet_receiver: directed and random word
// traffic with idling and backpressure on both handshakes, checked against a
// local frame parser. Depends on ymr_pkg and the design sources.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ymr_pkg::*;

  localparam int unsigned STORE_DEPTH  = 1029;
  localparam int unsigned RANDOM_WORDS = 300;
  localparam int unsigned LONG_HOLD    = 64;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 1000000;

  typedef enum int {FLAW_NONE, FLAW_HDR, FLAW_CRC, FLAW_DATA, FLAW_CUT} frame_flaw_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  ymr_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  ymr_out_t out_data_o;

  ymodem_packet_receiver #(.FRAME_DEPTH(STORE_DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser state
  logic        in_frame;
  logic        big_frame;
  logic [10:0] frame_pos;
  logic [15:0] crc_acc;
  logic [7:0]  frame_mem [STORE_DEPTH];
  int unsigned store_top;

  ymr_out_t    awaited_out [$];
  ymr_out_t    want;
  logic        idle_en = 1'b0;
  int unsigned hold_ticket = 0;
  int unsigned hold_served = 0;
  int unsigned sink_wait = 0;
  int unsigned n_cycles = 0;
  int unsigned n_words = 0, n_ignored = 0, n_reads = 0, n_stalls = 0;
  int unsigned n_good = 0, n_bad = 0, n_ctrl = 0, n_errors = 0;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
    return c;
  endfunction

  function automatic ymr_out_t parse_word(ymr_in_t w);
    ymr_out_t    r;
    logic [10:0] psz;
    int unsigned pos;
    r = '0;
    if (w.opcode == OP_READ) begin
      pos = HDR_LEN + w.read_index;
      if (pos < STORE_DEPTH) r.read_data = frame_mem[pos];
      n_reads++;
    end else if (!in_frame) begin
      if (w.rx_byte == CODE_SOH || w.rx_byte == CODE_STX) begin
        frame_mem[0] = w.rx_byte;
        big_frame = (w.rx_byte == CODE_STX);
        frame_pos = 11'd1;
        crc_acc = '0;
        in_frame = 1'b1;
        if (store_top == 0) store_top = 1;
      end else if (w.rx_byte == CODE_EOT) begin
        r.event_res = EV_EOT;
        n_ctrl++;
      end else if (w.rx_byte == CODE_CAN) begin
        r.event_res = EV_CAN;
        n_ctrl++;
      end else begin
        n_ignored++;
      end
    end else begin
      psz = big_frame ? 11'(LARGE_PAYLOAD) : 11'(SMALL_PAYLOAD);
      pos = frame_pos;
      if (pos < STORE_DEPTH) frame_mem[pos] = w.rx_byte;
      if (pos + 1 > store_top) store_top = pos + 1;
      if (pos >= HDR_LEN && pos < HDR_LEN + psz) crc_acc = crc16_byte(crc_acc, w.rx_byte);
      frame_pos = frame_pos + 11'd1;
      if (frame_pos >= psz + FRAME_EXTRA) begin
        if (8'(frame_mem[1] + frame_mem[2]) == 8'hFF &&
            {frame_mem[HDR_LEN + psz], frame_mem[HDR_LEN + psz + 1]} == crc_acc) begin
          r.event_res = EV_GOOD;
          r.block_number = frame_mem[1];
          r.payload_size = psz;
          n_good++;
        end else begin
          r.event_res = EV_ERROR;
          n_bad++;
        end
        in_frame = 1'b0;
        frame_pos = '0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    if (n_errors < 50) $display("MISMATCH %s: got %0d, expected %0d", what, got, exp_val);
    n_errors++;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_out.size() == 0) begin
        report_mismatch("word with nothing awaited", 32'(out_data_o), 32'd0);
      end else begin
        want = awaited_out.pop_front();
        if (out_data_o.event_res !== want.event_res)
          report_mismatch("event_res", 32'(out_data_o.event_res), 32'(want.event_res));
        if (out_data_o.block_number !== want.block_number)
          report_mismatch("block_number", 32'(out_data_o.block_number),
                          32'(want.block_number));
        if (out_data_o.payload_size !== want.payload_size)
          report_mismatch("payload_size", 32'(out_data_o.payload_size),
                          32'(want.payload_size));
        if (out_data_o.read_data !== want.read_data)
          report_mismatch("read_data", 32'(out_data_o.read_data), 32'(want.read_data));
      end
    end
  end

  // output side: random stall bursts, plus one long hold on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_ticket != hold_served) begin
      out_ready_i <= 1'b0;
      sink_wait   <= LONG_HOLD - 1;
      hold_served <= hold_ticket;
    end else if (sink_wait != 0) begin
      out_ready_i <= 1'b0;
      sink_wait   <= sink_wait - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready_i <= 1'b0;
      sink_wait   <= $urandom_range(0, 7);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_word(ymr_in_t w);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) begin
      n_stalls++;
      @(posedge clk_i);
    end
    awaited_out.push_back(parse_word(w));
    n_words++;
  endtask

  task automatic feed_byte(logic [7:0] b);
    ymr_in_t w;
    w.opcode     = OP_FEED;
    w.rx_byte    = b;
    w.read_index = 10'($urandom);
    send_word(w);
  endtask

  task automatic read_byte(logic [9:0] idx);
    ymr_in_t w;
    w.opcode     = OP_READ;
    w.rx_byte    = 8'($urandom);
    w.read_index = idx;
    send_word(w);
  endtask

  // only entries already written are read
  task automatic read_random();
    int unsigned top;
    if (store_top <= HDR_LEN) return;
    top = store_top - HDR_LEN - 1;
    if (top > 1023) top = 1023;
    case ($urandom_range(0, 3))
      0: read_byte(10'd0);
      1: read_byte(10'(top));
      default: read_byte(10'($urandom_range(0, top)));
    endcase
  endtask

  function automatic logic [7:0] pick_data();
    if ($urandom_range(0, 7) != 0) return 8'($urandom);
    case ($urandom_range(0, 5))
      0: return CODE_SOH;
      1: return CODE_STX;
      2: return CODE_EOT;
      3: return CODE_CAN;
      4: return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [7:0] pick_idle_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 1) == 0) b = $urandom_range(0, 1) ? CODE_EOT : CODE_CAN;
    else if (b == CODE_SOH || b == CODE_STX) b = 8'h00;
    return b;
  endfunction

  task automatic send_frame(logic big, logic [7:0] blk, frame_flaw_e flaw,
                            int unsigned read_odds);
    logic [7:0]  body [$];
    logic [7:0]  frame_bytes [$];
    logic [15:0] crc;
    logic [7:0]  cpl;
    int unsigned psz, cut_at;
    psz = big ? LARGE_PAYLOAD : SMALL_PAYLOAD;
    crc = '0;
    for (int i = 0; i < psz; i++) begin
      body.push_back(pick_data());
      crc = crc16_byte(crc, body[i]);
    end
    cpl = ~blk;
    case (flaw)
      FLAW_HDR:  cpl = cpl ^ 8'($urandom_range(1, 255));
      FLAW_CRC:  crc = crc ^ 16'($urandom_range(1, 65535));
      FLAW_DATA: body[$urandom_range(0, psz - 1)] ^= 8'($urandom_range(1, 255));
      default: ;
    endcase
    frame_bytes.push_back(big ? CODE_STX : CODE_SOH);
    frame_bytes.push_back(blk);
    frame_bytes.push_back(cpl);
    foreach (body[i]) frame_bytes.push_back(body[i]);
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
    cut_at = (flaw == FLAW_CUT) ? $urandom_range(1, frame_bytes.size() - 1)
                                : frame_bytes.size();
    for (int i = 0; i < cut_at; i++) begin
      feed_byte(frame_bytes[i]);
      if (read_odds != 0 && $urandom_range(1, read_odds) == 1) read_random();
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_out.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_idle_bytes();
    feed_byte(CODE_EOT);
    feed_byte(CODE_CAN);
    feed_byte(8'h00);
    feed_byte(8'hFF);
    feed_byte(8'h03);
    feed_byte(8'h17);
    feed_byte(8'h19);
    feed_byte(CODE_CAN);
    feed_byte(CODE_EOT);
    wait_drained();
  endtask

  task automatic test_small_packets();
    send_frame(1'b0, 8'h00, FLAW_NONE, 0);
    read_byte(10'd0);
    read_byte(10'd127);
    read_byte(10'd128);
    read_byte(10'd129);
    send_frame(1'b0, 8'hFF, FLAW_NONE, 0);
    send_frame(1'b0, 8'h01, FLAW_HDR, 0);
    send_frame(1'b0, 8'h80, FLAW_CRC, 0);
    send_frame(1'b0, 8'h7F, FLAW_DATA, 0);
    wait_drained();
  endtask

  task automatic test_large_packet();
    send_frame(1'b1, 8'hA5, FLAW_NONE, 0);
    read_byte(10'd1023);
    read_byte(10'd0);
    read_byte(10'd512);
    wait_drained();
  endtask

  // stale bytes from the large frame, and reads while a frame is collected
  task automatic test_stale_reads();
    send_frame(1'b0, 8'h3C, FLAW_NONE, 3);
    read_byte(10'd1000);
    read_byte(10'd1023);
    read_byte(10'd200);
    feed_byte(CODE_SOH);
    read_byte(10'd0);
    feed_byte(8'h10);
    feed_byte(8'hEF);
    feed_byte(8'h55);
    read_byte(10'd0);
    while (in_frame) feed_byte(8'($urandom));
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    hold_ticket++;
    send_frame(1'b0, 8'($urandom), FLAW_NONE, 4);
    wait_drained();
    idle_en = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned base, big_left, pick;
    base = n_words - n_ignored;
    big_left = 1;
    while (n_words - n_ignored - base < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(1'b0, 8'($urandom), FLAW_NONE, 16);
      end else if (pick < 67) begin
        send_frame(1'b0, 8'($urandom),
                   frame_flaw_e'($urandom_range(FLAW_HDR, FLAW_DATA)), 16);
      end else if (pick < 72) begin
        send_frame(1'b0, 8'($urandom), FLAW_CUT, 16);
        while (in_frame) feed_byte(8'($urandom));
      end else if (pick < 75 && big_left != 0) begin
        big_left--;
        send_frame(1'b1, 8'($urandom),
                   $urandom_range(0, 1) ? frame_flaw_e'(FLAW_NONE) : frame_flaw_e'(FLAW_CRC),
                   64);
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 6)) read_random();
      end else begin
        feed_byte(pick_idle_byte());
      end
    end
    wait_drained();
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    send_frame(1'b0, 8'($urandom), FLAW_NONE, 8);
    repeat (20) read_random();
    feed_byte(CODE_EOT);
    wait_drained();
  endtask

  initial begin
    in_frame  = 1'b0;
    big_frame = 1'b0;
    frame_pos = '0;
    crc_acc   = '0;
    store_top = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_en = 1'b1;
    test_idle_bytes();
    test_small_packets();
    test_large_packet();
    test_stale_reads();
    test_backpressure();
    test_random_traffic();
    test_steady_stream();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d words (%0d reads): %0d good packets, %0d bad packets, %0d EOT/CAN",
             n_words, n_reads, n_good, n_bad, n_ctrl);
    $display("Input side held off for %0d cycles by output backpressure", n_stalls);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ymr_pkg.sv
design/ymr_store.sv
design/ymr_ctrl.sv
design/ymodem_packet_receiver.sv
design/ymr_checker.sv
tb/tb.sv
